[design/fuca_pkg.sv]
// shared types and constants for the farthest-use cache admission block
`default_nettype none

package fuca_pkg;

	localparam logic [31:0] CAP_RESET = 32'd1048576;

	typedef struct packed {
		logic [31:0] object_id;
		logic [31:0] object_size;
		logic        recurs;
		logic [31:0] next_use_index;
	} fuca_req_t;

	typedef struct packed {
		logic       hit;
		logic       admitted;
		logic [6:0] evictions;
	} fuca_rsp_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] id;
		logic [31:0] size;
		logic [31:0] next_use;
	} fuca_entry_t;

	typedef struct packed {
		logic hit;
		logic free_found;
		logic victim_found;
	} fuca_scan_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_EVCHK,
		ST_EVSCAN,
		ST_FIN
	} fuca_state_t;

endpackage

`default_nettype wire

[design/fuca_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none

module fuca_ram #(
	parameter int WIDTH = 97,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[design/fuca_scan.sv]
// shared compare unit: hit match, lowest free slot and farthest-use victim over one pass
`default_nettype none

module fuca_scan
	import fuca_pkg::*;
#(
	parameter int ENTRIES = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       clr,
	input  wire logic                       beat,
	input  wire logic [$clog2(ENTRIES)-1:0] slot,
	input  wire fuca_entry_t                entry,
	input  wire logic [31:0]                key_id,
	input  wire logic [31:0]                key_size,
	input  wire logic [31:0]                now,
	output      fuca_scan_t                 status,
	output      logic [$clog2(ENTRIES)-1:0] free_slot,
	output      logic [$clog2(ENTRIES)-1:0] victim_slot,
	output      logic [31:0]                victim_size
);

	localparam int AW = $clog2(ENTRIES);

	fuca_scan_t     stat_q;
	logic [AW-1:0]  free_slot_q;
	logic [AW-1:0]  victim_slot_q;
	logic [31:0]    victim_size_q;
	logic [31:0]    best_q;
	logic [31:0]    use_gap;
	logic           match;
	logic           take_victim;

	always_comb begin
		use_gap = (entry.next_use > now) ? (entry.next_use - now) : (now - entry.next_use);
		match = entry.valid && (entry.id == key_id) && (entry.size == key_size);
		// >= so that later slots win ties
		take_victim = entry.valid && (!stat_q.victim_found || (use_gap >= best_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
		end else if (clr) begin
			stat_q <= '0;
		end else if (beat) begin
			if (match) begin
				stat_q.hit <= 1'b1;
			end
			if (!entry.valid) begin
				stat_q.free_found <= 1'b1;
			end
			if (take_victim) begin
				stat_q.victim_found <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat) begin
			if (!entry.valid && !stat_q.free_found) begin
				free_slot_q <= slot;
			end
			if (take_victim) begin
				best_q        <= use_gap;
				victim_slot_q <= slot;
				victim_size_q <= entry.size;
			end
		end
	end

	assign status      = stat_q;
	assign free_slot   = free_slot_q;
	assign victim_slot = victim_slot_q;
	assign victim_size = victim_size_q;

endmodule

`default_nettype wire

[design/farthest_use_cache_admission.sv]
// farthest-use cache admission: top level with request sequencer and entry store
// sequence: one lookup scan pass over all entries; an admission adds a capacity check,
// and each eviction one more scan pass and check before the response
// throughput: one request at a time; the next can be taken once the response turns valid
// reset: async active low; a clearing pass over all entries, capacity back to 1048576 bytes
`default_nettype none

module farthest_use_cache_admission
	import fuca_pkg::*;
#(
	parameter int ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output      logic        req_stall,
	input  wire fuca_req_t   req,
	output      logic        rsp_valid,
	input  wire logic        rsp_stall,
	output      fuca_rsp_t   rsp,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int UW = 35 + $clog2(ENTRIES);
	localparam logic [CW-1:0] END_C  = CW'(ENTRIES);
	localparam logic [CW-1:0] LAST_C = CW'(ENTRIES - 1);

	fuca_state_t   state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_slot_s1;
	logic [31:0]   cap_q;
	logic [32:0]   used_q;
	logic [31:0]   now_q;
	logic          rsp_valid_q;
	fuca_rsp_t     rsp_q;
	fuca_req_t     req_q;
	logic          hit_q;
	logic          adm_q;
	logic [6:0]    evict_q;
	logic [UW-1:0] work_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	fuca_entry_t   ram_wdata;
	fuca_entry_t   ram_rdata;

	logic          scan_clr;
	logic          scanning;
	logic          scan_done;
	logic          admit_ok;
	logic          over;
	logic          rsp_load;
	fuca_scan_t    scan;
	logic [AW-1:0] free_slot;
	logic [AW-1:0] victim_slot;
	logic [31:0]   victim_size;

	fuca_ram #(
		.WIDTH($bits(fuca_entry_t)),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	fuca_scan #(
		.ENTRIES(ENTRIES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (scan_clr),
		.beat       (rd_vld_s1),
		.slot       (rd_slot_s1),
		.entry      (ram_rdata),
		.key_id     (req_q.object_id),
		.key_size   (req_q.object_size),
		.now        (now_q),
		.status     (scan),
		.free_slot  (free_slot),
		.victim_slot(victim_slot),
		.victim_size(victim_size)
	);

	assign scanning  = (state_q == ST_LOOKUP) || (state_q == ST_EVSCAN);
	assign scan_done = (cnt_q == END_C) && !rd_vld_s1;
	assign admit_ok  = !scan.hit && req_q.recurs && (req_q.object_size < cap_q) &&
		scan.free_found;
	// a wrapped negative total has its top bit set and so also counts as over
	assign over      = work_q > UW'(cap_q);
	assign rsp_load  = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = '0;
		scan_clr  = 1'b0;
		req_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (cnt_q == LAST_C) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					scan_clr = 1'b1;
					state_d  = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (scan_done) begin
					if (admit_ok) begin
						ram_we    = 1'b1;
						ram_waddr = free_slot;
						ram_wdata = '{valid: 1'b1, id: req_q.object_id,
							size: req_q.object_size, next_use: req_q.next_use_index};
						state_d   = ST_EVCHK;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_EVCHK: begin
				if (over) begin
					scan_clr = 1'b1;
					state_d  = ST_EVSCAN;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_EVSCAN: begin
				if (scan_done) begin
					if (scan.victim_found) begin
						ram_we    = 1'b1;
						ram_waddr = victim_slot;
						state_d   = ST_EVCHK;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			cap_q       <= CAP_RESET;
			used_q      <= '0;
			now_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (state_q == ST_CLEAR || scan_clr) begin
				cnt_q <= scan_clr ? '0 : cnt_q + 1'b1;
			end else if (scanning && cnt_q != END_C) begin
				cnt_q <= cnt_q + 1'b1;
			end
			rd_vld_s1 <= scanning && (cnt_q != END_C);

			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end

			if ((state_q == ST_EVCHK && !over) ||
				(state_q == ST_EVSCAN && scan_done && !scan.victim_found)) begin
				used_q <= work_q[32:0];
			end

			if (rsp_load) begin
				now_q       <= now_q + 1'b1;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_slot_s1 <= cnt_q[AW-1:0];
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == ST_LOOKUP && scan_done) begin
			hit_q   <= scan.hit;
			adm_q   <= admit_ok;
			evict_q <= '0;
			work_q  <= UW'(used_q) + UW'(req_q.object_size);
		end
		if (state_q == ST_EVSCAN && scan_done && scan.victim_found) begin
			work_q  <= work_q - UW'(victim_size);
			evict_q <= evict_q + 1'b1;
		end
		if (rsp_load) begin
			rsp_q <= '{hit: hit_q, admitted: adm_q, evictions: evict_q};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[tb/sv/farthest_use_cache_admission_tb.sv]
// testbench for farthest_use_cache_admission: random and directed requests checked by a scoreboard
module farthest_use_cache_admission_tb;
	import fuca_pkg::*;

	localparam int ENTRIES     = 64;
	localparam int POOL        = 48;
	localparam int HOLD_CYCLES = 3000;
	localparam int MAX_REPORTS = 10;
	localparam int CYCLE_LIMIT = 2000000;

	typedef enum int {
		TRAFFIC_NORMAL,
		TRAFFIC_ACCUMULATE,
		TRAFFIC_FLOOD
	} traffic_t;

	class admission_scoreboard;
		bit          slot_valid [ENTRIES];
		bit [31:0]   slot_id    [ENTRIES];
		bit [31:0]   slot_size  [ENTRIES];
		bit [31:0]   slot_next  [ENTRIES];
		bit [63:0]   bytes_held = 0;
		bit [31:0]   now_index  = 0;
		bit [31:0]   capacity   = CAP_RESET;
		fuca_rsp_t   outcome_q [$];
		int          mismatches = 0;

		function void set_capacity(bit [31:0] value);
			capacity = value;
		endfunction

		// runs one request through the cache and queues the outcome it must produce
		function void note_request(fuca_req_t r);
			fuca_rsp_t   o;
			int          free_slot;
			int          victim;
			bit [31:0]   far;
			bit [31:0]   d;
			o = '0;
			free_slot = -1;
			for (int s = 0; s < ENTRIES; s++)
				if (slot_valid[s] && slot_id[s] == r.object_id && slot_size[s] == r.object_size)
					o.hit = 1'b1;
			if (!o.hit && r.recurs && r.object_size < capacity) begin
				for (int s = ENTRIES - 1; s >= 0; s--)
					if (!slot_valid[s])
						free_slot = s;
				if (free_slot >= 0) begin
					slot_valid[free_slot] = 1'b1;
					slot_id[free_slot]    = r.object_id;
					slot_size[free_slot]  = r.object_size;
					slot_next[free_slot]  = r.next_use_index;
					bytes_held += r.object_size;
					o.admitted = 1'b1;
					while (bytes_held > {32'd0, capacity}) begin
						victim = -1;
						far = 0;
						// ties go to the highest slot
						for (int s = 0; s < ENTRIES; s++) begin
							if (slot_valid[s]) begin
								d = (slot_next[s] > now_index) ? slot_next[s] - now_index
									: now_index - slot_next[s];
								if (victim < 0 || d >= far) begin
									far = d;
									victim = s;
								end
							end
						end
						if (victim < 0)
							break;
						slot_valid[victim] = 1'b0;
						bytes_held -= slot_size[victim];
						o.evictions = o.evictions + 7'd1;
					end
				end
			end
			bytes_held &= 64'h1_FFFF_FFFF;
			now_index++;
			outcome_q.push_back(o);
		endfunction

		function void flag(string what, int want, int got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch on %s: expected %0d, got %0d", what, want, got);
		endfunction

		function void check_outcome(fuca_rsp_t got);
			fuca_rsp_t want;
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("response hit=%0d admitted=%0d evictions=%0d with no request pending",
						got.hit, got.admitted, got.evictions);
				return;
			end
			want = outcome_q.pop_front();
			if (got.hit !== want.hit)
				flag("hit", want.hit, got.hit);
			if (got.admitted !== want.admitted)
				flag("admitted", want.admitted, got.admitted);
			if (got.evictions !== want.evictions)
				flag("evictions", want.evictions, got.evictions);
		endfunction
	endclass

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        req_valid   = 1'b0;
	fuca_req_t   req         = '0;
	logic        rsp_stall   = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [31:0] cfg_wr_data = CAP_RESET;
	logic        req_stall;
	logic        rsp_valid;
	fuca_rsp_t   rsp;

	admission_scoreboard board = new;

	int          send_idle_pct = 11;
	int          recv_stall_pct = 72;
	bit          hold_armed = 1'b0;
	bit          hold_taken = 1'b0;
	int          hold_left = 0;
	int          cycle_count = 0;
	bit [31:0]   cap_now = CAP_RESET;
	bit [31:0]   last_next = 0;
	bit [31:0]   pool_id   [POOL];
	bit [31:0]   pool_size [POOL];

	farthest_use_cache_admission #(
		.ENTRIES(ENTRIES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// response side: check, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				board.check_outcome(rsp);
			if (hold_armed && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left <= HOLD_CYCLES;
				rsp_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic send_request(input fuca_req_t r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		board.note_request(r);
	endtask

	task automatic offer(input bit [31:0] id, input bit [31:0] size, input bit rec,
			input bit [31:0] next);
		fuca_req_t r;
		r.object_id = id;
		r.object_size = size;
		r.recurs = rec;
		r.next_use_index = next;
		send_request(r);
	endtask

	// capacity only changes once every request has answered
	task automatic write_capacity(input bit [31:0] value);
		req_valid <= 1'b0;
		while (board.outcome_q.size() != 0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		board.set_capacity(value);
		cap_now = value;
		cfg_wr_en <= 1'b0;
	endtask

	function automatic bit [31:0] pick_size(bit [31:0] cap);
		int roll;
		bit [31:0] lim;
		roll = $urandom_range(99);
		lim = (cap / 4 > 1) ? cap / 4 : 32'd1;
		if (roll < 3)
			return 32'd0;
		if (roll < 73)
			return $urandom_range(1, lim);
		if (roll < 83)
			return cap - 32'd1;
		if (roll < 88)
			return cap;
		return $urandom;
	endfunction

	function automatic bit [31:0] pick_next();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			last_next = board.now_index + $urandom_range(1, 300);
		else if (roll < 75)
			last_next = board.now_index - $urandom_range(0, 300);
		else if (roll < 90)
			last_next = $urandom;
		// otherwise reuse the previous next-use index to force equal distances
		return last_next;
	endfunction

	function automatic fuca_req_t make_request(traffic_t mix);
		fuca_req_t r;
		int k;
		k = $urandom_range(POOL - 1);
		r.next_use_index = pick_next();
		case (mix)
			TRAFFIC_FLOOD: begin
				r.object_id = $urandom;
				r.object_size = $urandom_range(0, 50);
				r.recurs = 1'b1;
			end
			TRAFFIC_ACCUMULATE: begin
				r.object_id = ($urandom_range(99) < 80) ? $urandom : pool_id[k];
				r.object_size = $urandom_range(0, 1000);
				r.recurs = ($urandom_range(99) < 80);
			end
			default: begin
				if ($urandom_range(99) < 45) begin
					// revisit a known object so hits are likely
					r.object_id = pool_id[k];
					r.object_size = pool_size[k];
				end else begin
					r.object_id = ($urandom_range(99) < 60) ? pool_id[k] : $urandom;
					r.object_size = pick_size(cap_now);
				end
				r.recurs = ($urandom_range(99) < 85);
			end
		endcase
		return r;
	endfunction

	task automatic run_phase(input traffic_t mix, input int count);
		for (int i = 0; i < POOL; i++)
			pool_size[i] = pick_size(cap_now);
		repeat (count)
			send_request(make_request(mix));
	endtask

	initial begin : stimulus
		for (int i = 0; i < POOL; i++)
			pool_id[i] = $urandom;

		// directed requests at reset capacity
		offer(32'd0, 32'd0, 1'b1, 32'd0);
		offer(32'd0, 32'd0, 1'b1, 32'd0);
		offer(32'd0, 32'd1, 1'b0, 32'hFFFF_FFFF);
		offer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		offer(32'd5, 32'd1048575, 1'b1, 32'd100);
		offer(32'd6, 32'd1048576, 1'b1, 32'd100);
		offer(32'd7, 32'd10, 1'b1, board.now_index + 32'd2);
		// four entries sharing one next-use index
		offer(32'd8, 32'd300000, 1'b1, 32'd500);
		offer(32'd9, 32'd300000, 1'b1, 32'd500);
		offer(32'd10, 32'd300000, 1'b1, 32'd500);
		offer(32'd11, 32'd300000, 1'b1, 32'd500);
		// equal distance, one ahead and one behind
		offer(32'd12, 32'd100, 1'b1, board.now_index + 32'd1000);
		offer(32'd13, 32'd700000, 1'b1, board.now_index - 32'd999);

		write_capacity(32'hFFFF_FFFF);
		offer(32'd14, 32'hFFFF_FFFE, 1'b1, board.now_index);
		offer(32'd14, 32'hFFFF_FFFE, 1'b1, board.now_index);

		// capacity now far below the bytes held
		write_capacity(32'd1);
		offer(32'd16, 32'd0, 1'b1, board.now_index + 32'd5);
		offer(32'd17, 32'd1, 1'b1, board.now_index);

		write_capacity(32'd0);
		offer(32'd18, 32'd0, 1'b1, board.now_index);
		offer(32'd16, 32'd0, 1'b1, board.now_index);

		// sender idles rarely, receiver often
		write_capacity(32'd4000);
		run_phase(TRAFFIC_NORMAL, 45);
		write_capacity(32'd1);
		run_phase(TRAFFIC_NORMAL, 45);
		write_capacity($urandom_range(5000, 200000000));
		run_phase(TRAFFIC_NORMAL, 45);

		send_idle_pct = 72;
		recv_stall_pct = 11;
		write_capacity(32'hFFFF_FFFF);
		run_phase(TRAFFIC_ACCUMULATE, 45);
		write_capacity(32'd2000);
		run_phase(TRAFFIC_NORMAL, 45);
		write_capacity(32'd0);
		run_phase(TRAFFIC_NORMAL, 45);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_capacity(CAP_RESET);
		hold_armed = 1'b1;
		run_phase(TRAFFIC_NORMAL, 45);
		write_capacity($urandom_range(5000, 32'hFFFF_FFFF));
		run_phase(TRAFFIC_NORMAL, 45);
		// last, since a full cache never admits again
		write_capacity(32'hFFFF_FFFF);
		run_phase(TRAFFIC_FLOOD, 80);

		req_valid <= 1'b0;
		while (board.outcome_q.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);
		if (board.mismatches == 0 && board.outcome_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
